// ----- src/assert_macros.svh -----
// Assertion macros shared by the stereo chorus delay RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define SCD_ASSERT(name, clk, rst_n, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("chorus delay: property violated");
`define SCD_ASSERT_NEVER(name, clk, rst_n, cond) \
    name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("chorus delay: forbidden condition seen");
`else
`define SCD_ASSERT(name, clk, rst_n, prop)
`define SCD_ASSERT_NEVER(name, clk, rst_n, cond)
`endif
`endif

// ----- src/scd_pkg.sv -----
// Types, constants and the sine table of the stereo chorus delay.
package scd_pkg;

    // Delay store depth and sine table size (both powers of two)
    localparam int STORE_DEPTH  = 4096;
    localparam int ADDR_W       = $clog2(STORE_DEPTH);
    localparam int SINE_ENTRIES = 256;
    localparam int SINE_BITS    = $clog2(SINE_ENTRIES);

    // Shared multiplier operand and product widths
    localparam int OPND_W = 17;
    localparam int PROD_W = 2 * OPND_W;

    // Register reset values
    localparam logic [10:0] BASE_DELAY_RST = 11'd1000;
    localparam logic [9:0]  MOD_DEPTH_RST  = 10'd500;
    localparam logic [31:0] LFO_STEP_RST   = 32'd9740;
    localparam logic [15:0] WET_GAIN_RST   = 16'd32768;

    // Fixed-point constants of the sine evaluation
    localparam logic [63:0] Q30_ONE    = 64'd1 << 30;
    localparam logic [63:0] TWO_PI_Q30 = 64'd6746518852;

    // Configuration register indexes
    typedef enum logic [7:0] {
        REG_BASE_DELAY = 8'd0,
        REG_MOD_DEPTH  = 8'd1,
        REG_LFO_STEP   = 8'd2,
        REG_WET_GAIN   = 8'd3
    } cfg_reg_t;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DEPTH,
        ST_ADDR,
        ST_RD_PREV,
        ST_RD_NEXT,
        ST_INTERP,
        ST_TAP,
        ST_GAIN,
        ST_MIX,
        ST_WRITE,
        ST_OUT
    } state_t;

    // Shared multiplier operations
    typedef enum logic [1:0] {
        ALU_DEPTH,
        ALU_INTERP,
        ALU_GAIN
    } alu_op_t;

    typedef struct packed {
        logic    en;
        alu_op_t op;
    } alu_ctrl_t;

    typedef logic signed [15:0] sine_table_t [SINE_ENTRIES];

    // Build the quantized sine: odd polynomial on a quarter wave, folded
    function automatic sine_table_t build_sine_table();
        sine_table_t tab;
        logic [63:0] u;
        logic [63:0] v;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] s;
        logic [63:0] r;
        for (int i = 0; i < SINE_ENTRIES; i++)
        begin
            u = 64'(i) << (32 - SINE_BITS);
            v = u & 64'h7FFF_FFFF;
            if (v > Q30_ONE)
            begin
                v = (64'd1 << 31) - v;
            end
            x  = (v * TWO_PI_Q30) >> 32;
            x2 = (x * x) >> 30;
            t  = Q30_ONE - x2 / 64'd110;
            t  = Q30_ONE - ((x2 * t) >> 30) / 64'd72;
            t  = Q30_ONE - ((x2 * t) >> 30) / 64'd42;
            t  = Q30_ONE - ((x2 * t) >> 30) / 64'd20;
            t  = Q30_ONE - ((x2 * t) >> 30) / 64'd6;
            s  = (x * t) >> 30;
            r  = (s * 64'd32767 + (64'd1 << 29)) >> 30;
            if (r > 64'd32767)
            begin
                r = 64'd32767;
            end
            tab[i] = u[31] ? -(16'(r)) : 16'(r);
        end
        return tab;
    endfunction

    localparam sine_table_t SINE_TABLE = build_sine_table();

endpackage

// ----- src/scd_ram.sv -----
// Simple dual-port RAM with registered read data.
module scd_ram #(
    parameter int ADDR_W = 12,
    parameter int DATA_W = 16
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [2**ADDR_W];
    logic [DATA_W-1:0] rdata_reg;

    // Write one word, register one read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- src/scd_alu.sv -----
// Shared signed multiplier with operand selection and registered product.
module scd_alu (
    input  logic                              clk,
    input  scd_pkg::alu_ctrl_t                ctrl,
    input  logic [15:0]                       sine_off,
    input  logic [9:0]                        mod_depth,
    input  logic signed [16:0]                diff,
    input  logic [14:0]                       frac,
    input  logic signed [15:0]                tap,
    input  logic [15:0]                       wet_gain,
    output logic signed [scd_pkg::PROD_W-1:0] prod
);

    logic signed [scd_pkg::OPND_W-1:0] op_a;
    logic signed [scd_pkg::OPND_W-1:0] op_b;
    logic signed [scd_pkg::PROD_W-1:0] prod_reg;

    // Select operands for the current step
    always_comb
    begin
        unique case (ctrl.op)
            scd_pkg::ALU_DEPTH:
            begin
                op_a = {1'b0, sine_off};
                op_b = {7'd0, mod_depth};
            end
            scd_pkg::ALU_INTERP:
            begin
                op_a = diff;
                op_b = {2'd0, frac};
            end
            scd_pkg::ALU_GAIN:
            begin
                op_a = {tap[15], tap};
                op_b = {1'b0, wet_gain};
            end
            default:
            begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    // Multiply and hold the product for the next step
    always_ff @(posedge clk)
    begin
        if (ctrl.en)
        begin
            prod_reg <= op_a * op_b;
        end
    end

    assign prod = prod_reg;

endmodule

// ----- src/stereo_chorus_delay_core.sv -----
// Stereo chorus delay: sequencer, delay store and mixing around one multiplier.
//
// One mono dry word in gives one stereo word out (left in the low half). After
// acceptance the input stays not ready until the result is loaded, so a new
// dry word is taken only once the previous one is through. Each of the two
// taps passes eight steps (depth multiply, tap address, two delay store reads,
// interpolation multiply, rounding, gain multiply, mix), paced by the single
// shared multiplier and the one read port of the store. Then the dry word is
// written and the result loaded, in that order. If the previous stereo word is
// still waiting at the output, the block holds in that last step until it is
// taken. There is no clearing pass after reset: a write index and a wrap flag
// tell which entries were written, and unwritten entries read as zero.
// Configuration writes are always taken and must come while idle.
`include "assert_macros.svh"

module stereo_chorus_delay_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [15:0] dry_sample
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [15:0] left_sample, [31:16] right_sample
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    localparam int AW = scd_pkg::ADDR_W;

    scd_pkg::state_t state_reg, state_next;

    logic [10:0] base_reg, base_next;
    logic [9:0]  depth_reg, depth_next;
    logic [31:0] step_reg, step_next;
    logic [15:0] gain_reg, gain_next;

    logic [31:0]   phase_reg, phase_next;
    logic [AW-1:0] widx_reg, widx_next;
    logic          wrapped_reg, wrapped_next;
    logic          side_reg, side_next;
    logic          out_valid_reg, out_valid_next;

    logic signed [15:0] dry_reg, dry_next;
    logic [AW-1:0]      prev_reg, prev_next;
    logic [14:0]        frac_reg, frac_next;
    logic signed [15:0] a_reg, a_next;
    logic signed [15:0] tap_reg, tap_next;
    logic signed [15:0] left_reg, left_next;
    logic signed [15:0] right_reg, right_next;
    logic [31:0]        out_data_reg, out_data_next;
    logic               rd_valid_reg;

    logic               ram_we;
    logic [AW-1:0]      raddr;
    logic [15:0]        rdata;
    logic signed [15:0] rd_word;

    scd_pkg::alu_ctrl_t                alu_ctrl;
    logic signed [scd_pkg::PROD_W-1:0] alu_prod;

    logic [scd_pkg::SINE_BITS-1:0] sine_idx;
    logic signed [15:0]            sine_val;
    logic [15:0]                   sine_off;
    logic signed [16:0]            diff;
    logic [26:0]                   dly;
    logic [12:0]                   back_full;
    logic signed [32:0]            tap_acc;
    logic signed [33:0]            mix_acc;
    logic signed [17:0]            mix_y;
    logic signed [15:0]            mix_sat;

    // Sine lookup for the current tap; the right tap is half an LFO period ahead
    assign sine_idx = phase_reg[31 -: scd_pkg::SINE_BITS]
                    ^ {side_reg, {(scd_pkg::SINE_BITS-1){1'b0}}};
    assign sine_val = scd_pkg::SINE_TABLE[sine_idx];
    assign sine_off = {~sine_val[15], sine_val[14:0]};

    // Unwritten store entries read as zero
    assign rd_word = rd_valid_reg ? $signed(rdata) : 16'sd0;
    assign diff    = {rd_word[15], rd_word} - {a_reg[15], a_reg};

    // Tap delay in Q.15 samples and its whole-sample part, rounded up
    assign dly       = {1'b0, base_reg, 15'd0} + {1'b0, alu_prod[25:0]};
    assign back_full = {1'b0, dly[26:15]} + 13'(dly[14:0] != 15'd0);

    // Interpolation rounding and mix rounding with saturation
    assign tap_acc = {{2{a_reg[15]}}, a_reg, 15'd0} + 33'(alu_prod) + 33'sd16384;
    assign mix_acc = {{2{dry_reg[15]}}, dry_reg, 16'd0} + alu_prod + 34'sd32768;
    assign mix_y   = mix_acc[33:16];

    always_comb
    begin
        if (mix_y > 18'sd32767)
        begin
            mix_sat = 16'sh7FFF;
        end
        else if (mix_y < -18'sd32768)
        begin
            mix_sat = -16'sh8000;
        end
        else
        begin
            mix_sat = mix_y[15:0];
        end
    end

    // Sequencer: next state, datapath next values and strobes
    always_comb
    begin
        state_next     = state_reg;
        base_next      = base_reg;
        depth_next     = depth_reg;
        step_next      = step_reg;
        gain_next      = gain_reg;
        phase_next     = phase_reg;
        widx_next      = widx_reg;
        wrapped_next   = wrapped_reg;
        side_next      = side_reg;
        out_valid_next = out_valid_reg;
        dry_next       = dry_reg;
        prev_next      = prev_reg;
        frac_next      = frac_reg;
        a_next         = a_reg;
        tap_next       = tap_reg;
        left_next      = left_reg;
        right_next     = right_reg;
        out_data_next  = out_data_reg;
        ram_we         = 1'b0;
        raddr          = prev_reg;
        alu_ctrl.en    = 1'b0;
        alu_ctrl.op    = scd_pkg::ALU_DEPTH;
        s_axis_tready  = 1'b0;

        // Take configuration writes; unknown indexes are dropped
        if (cfg_valid)
        begin
            unique case (cfg_index)
                scd_pkg::REG_BASE_DELAY: base_next  = cfg_data[10:0];
                scd_pkg::REG_MOD_DEPTH:  depth_next = cfg_data[9:0];
                scd_pkg::REG_LFO_STEP:   step_next  = cfg_data;
                scd_pkg::REG_WET_GAIN:   gain_next  = cfg_data[15:0];
                default: ;
            endcase
        end

        // Release the output word once taken
        if (m_axis_tvalid && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            scd_pkg::ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid)
                begin
                    dry_next   = $signed(s_axis_tdata);
                    phase_next = phase_reg + step_reg;
                    side_next  = 1'b0;
                    state_next = scd_pkg::ST_DEPTH;
                end
            end
            scd_pkg::ST_DEPTH:
            begin
                alu_ctrl.en = 1'b1;
                alu_ctrl.op = scd_pkg::ALU_DEPTH;
                state_next  = scd_pkg::ST_ADDR;
            end
            scd_pkg::ST_ADDR:
            begin
                prev_next  = widx_reg - AW'(back_full);
                frac_next  = 15'd0 - dly[14:0];
                state_next = scd_pkg::ST_RD_PREV;
            end
            scd_pkg::ST_RD_PREV:
            begin
                raddr      = prev_reg;
                state_next = scd_pkg::ST_RD_NEXT;
            end
            scd_pkg::ST_RD_NEXT:
            begin
                raddr      = prev_reg + AW'(1);
                a_next     = rd_word;
                state_next = scd_pkg::ST_INTERP;
            end
            scd_pkg::ST_INTERP:
            begin
                alu_ctrl.en = 1'b1;
                alu_ctrl.op = scd_pkg::ALU_INTERP;
                state_next  = scd_pkg::ST_TAP;
            end
            scd_pkg::ST_TAP:
            begin
                tap_next   = tap_acc[30:15];
                state_next = scd_pkg::ST_GAIN;
            end
            scd_pkg::ST_GAIN:
            begin
                alu_ctrl.en = 1'b1;
                alu_ctrl.op = scd_pkg::ALU_GAIN;
                state_next  = scd_pkg::ST_MIX;
            end
            scd_pkg::ST_MIX:
            begin
                if (side_reg)
                begin
                    right_next = mix_sat;
                    state_next = scd_pkg::ST_WRITE;
                end
                else
                begin
                    left_next  = mix_sat;
                    side_next  = 1'b1;
                    state_next = scd_pkg::ST_DEPTH;
                end
            end
            scd_pkg::ST_WRITE:
            begin
                ram_we    = 1'b1;
                widx_next = widx_reg + AW'(1);
                if (widx_reg == AW'(scd_pkg::STORE_DEPTH - 1))
                begin
                    wrapped_next = 1'b1;
                end
                state_next = scd_pkg::ST_OUT;
            end
            scd_pkg::ST_OUT:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_data_next  = {right_reg, left_reg};
                    out_valid_next = 1'b1;
                    state_next     = scd_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = scd_pkg::ST_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= scd_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Control and configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg      <= scd_pkg::BASE_DELAY_RST;
            depth_reg     <= scd_pkg::MOD_DEPTH_RST;
            step_reg      <= scd_pkg::LFO_STEP_RST;
            gain_reg      <= scd_pkg::WET_GAIN_RST;
            phase_reg     <= 32'd0;
            widx_reg      <= '0;
            wrapped_reg   <= 1'b0;
            side_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            base_reg      <= base_next;
            depth_reg     <= depth_next;
            step_reg      <= step_next;
            gain_reg      <= gain_next;
            phase_reg     <= phase_next;
            widx_reg      <= widx_next;
            wrapped_reg   <= wrapped_next;
            side_reg      <= side_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers; track whether the word being read was ever written
    always_ff @(posedge clk)
    begin
        dry_reg      <= dry_next;
        prev_reg     <= prev_next;
        frac_reg     <= frac_next;
        a_reg        <= a_next;
        tap_reg      <= tap_next;
        left_reg     <= left_next;
        right_reg    <= right_next;
        out_data_reg <= out_data_next;
        rd_valid_reg <= wrapped_reg || (raddr < widx_reg);
    end

    scd_ram #(
        .ADDR_W (AW),
        .DATA_W (16)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (widx_reg),
        .wdata (dry_reg),
        .raddr (raddr),
        .rdata (rdata)
    );

    scd_alu u_alu (
        .clk       (clk),
        .ctrl      (alu_ctrl),
        .sine_off  (sine_off),
        .mod_depth (depth_reg),
        .diff      (diff),
        .frac      (frac_reg),
        .tap       (tap_reg),
        .wet_gain  (gain_reg),
        .prod      (alu_prod)
    );

    assign cfg_ready     = 1'b1;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    `SCD_ASSERT(a_accept_starts_taps, clk, rst_n, (s_axis_tvalid && s_axis_tready) |=> (state_reg == scd_pkg::ST_DEPTH && !side_reg))
    `SCD_ASSERT(a_write_after_right, clk, rst_n, (state_reg == scd_pkg::ST_WRITE) |-> side_reg)
    `SCD_ASSERT(a_write_advances, clk, rst_n, (state_reg == scd_pkg::ST_WRITE) |=> (widx_reg == $past(widx_reg) + AW'(1)))
    `SCD_ASSERT(a_wrap_sticks, clk, rst_n, wrapped_reg |=> wrapped_reg)
    `SCD_ASSERT_NEVER(a_phase_only_on_accept, clk, rst_n, ($past(state_reg) != scd_pkg::ST_IDLE) && !$stable(phase_reg))

endmodule
